### sv/mcfr_pkg.sv
// Shared types, codes and helpers for the motor command frame receiver.
`timescale 1ns / 1ps
package mcfr_pkg;

  localparam int MAX_PAYLOAD_DEF = 32;
  localparam int QUEUE_DEPTH_DEF = 2;
  localparam int LEN_W           = 6;

  localparam logic [7:0]  HDR1_RST  = 8'hAA;
  localparam logic [7:0]  HDR2_RST  = 8'h55;
  localparam logic [15:0] LIMIT_RST = 16'd500;

  localparam logic [7:0] CMD_HALT_ALL   = 8'h01;
  localparam logic [7:0] CMD_SET_DRIVES = 8'h02;
  localparam logic [7:0] CMD_BUZZER     = 8'h04;
  localparam logic [7:0] CMD_ODOM_RST   = 8'h06;

  localparam logic OP_BYTE = 1'b0;
  localparam logic OP_TICK = 1'b1;

  typedef enum logic [1:0] {
    REG_HDR1  = 2'd0,
    REG_HDR2  = 2'd1,
    REG_LIMIT = 2'd2
  } reg_idx_t;

  typedef enum logic [1:0] {
    ST_NONE = 2'd0,
    ST_OK   = 2'd1,
    ST_CSUM = 2'd2,
    ST_LEN  = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    PH_HDR1 = 3'd0,
    PH_HDR2 = 3'd1,
    PH_SEQ  = 3'd2,
    PH_CMD  = 3'd3,
    PH_LEN  = 3'd4,
    PH_PAY  = 3'd5,
    PH_SUM  = 3'd6
  } phase_t;

  typedef struct packed {
    logic       is_tick;
    status_t    status;
    logic [7:0] cmd;
    logic [7:0] pay0;
    logic [7:0] pay1;
    logic       len_ge2;
  } ev_t;

  typedef struct packed {
    logic       fwd;
    logic       rev;
    logic [7:0] duty;
  } drive_t;

  typedef struct packed {
    drive_t     left;
    drive_t     right;
    status_t    status;
    logic [7:0] cmd;
    logic       beep;
    logic       odo_rst;
    logic       holding;
    logic       link;
  } res_t;

  function automatic drive_t decode_drive(input logic [7:0] v);
    drive_t d;
    d.fwd  = (v != 8'd0) && !v[7];
    d.rev  = v[7];
    d.duty = v[7] ? (8'd0 - v) : v;
    return d;
  endfunction

endpackage

### sv/mcfr_fifo.sv
// Small register queue with push/full and pop/empty sides.
`timescale 1ns / 1ps
module mcfr_fifo #(
  parameter int W     = 8,
  parameter int DEPTH = 2
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         push,
  input  logic [W-1:0] din,
  output logic         full,
  input  logic         pop,
  output logic [W-1:0] dout,
  output logic         empty
);
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [W-1:0]  mem_r [DEPTH];
  logic [AW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [AW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic          push_ok, pop_ok;

  assign full    = (count_r == CW'(DEPTH));
  assign empty   = (count_r == '0);
  assign push_ok = push && !full;
  assign pop_ok  = pop && !empty;
  assign dout    = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    if (push_ok) begin
      wr_ptr_nxt = (wr_ptr_r == AW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop_ok) begin
      rd_ptr_nxt = (rd_ptr_r == AW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    count_nxt = count_r + CW'(push_ok) - CW'(pop_ok);
  end

  always_ff @(posedge clk) begin
    if (push_ok) begin
      mem_r[wr_ptr_r] <= din;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end
endmodule

### sv/mcfr_front.sv
// Frame parser: hunts headers, checks length and checksum, emits one event per transaction.
`timescale 1ns / 1ps
module mcfr_front import mcfr_pkg::*; #(
  parameter int MAX_PAYLOAD = MAX_PAYLOAD_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       accept,
  input  logic       op,
  input  logic [7:0] rx_byte,
  input  logic [7:0] hdr1,
  input  logic [7:0] hdr2,
  output ev_t        ev
);
  phase_t             phase_r, phase_nxt;
  logic [7:0]         cmd_r, cmd_nxt;
  logic [LEN_W-1:0]   len_r, len_nxt;
  logic [LEN_W-1:0]   cnt_r, cnt_nxt;
  logic [7:0]         xor_r, xor_nxt;
  logic [7:0]         pay0_r, pay0_nxt;
  logic [7:0]         pay1_r, pay1_nxt;
  logic               byte_go;
  logic               too_long;
  logic [LEN_W-1:0]   cnt_inc;
  status_t            status;

  assign byte_go  = accept && (op == OP_BYTE);
  assign too_long = rx_byte > 8'(MAX_PAYLOAD);
  assign cnt_inc  = cnt_r + 1'b1;

  always_comb begin
    phase_nxt = phase_r;
    if (byte_go) begin
      unique case (phase_r)
        PH_HDR2: phase_nxt = (rx_byte == hdr2) ? PH_SEQ : PH_HDR1;
        PH_SEQ:  phase_nxt = PH_CMD;
        PH_CMD:  phase_nxt = PH_LEN;
        PH_LEN: begin
          if (too_long) begin
            phase_nxt = PH_HDR1;
          end else begin
            phase_nxt = (rx_byte == 8'd0) ? PH_SUM : PH_PAY;
          end
        end
        PH_PAY:  phase_nxt = (cnt_inc >= len_r) ? PH_SUM : PH_PAY;
        PH_SUM:  phase_nxt = PH_HDR1;
        default: phase_nxt = (rx_byte == hdr1) ? PH_HDR2 : PH_HDR1;
      endcase
    end
  end

  always_comb begin
    cmd_nxt  = cmd_r;
    len_nxt  = len_r;
    cnt_nxt  = cnt_r;
    xor_nxt  = xor_r;
    pay0_nxt = pay0_r;
    pay1_nxt = pay1_r;
    status   = ST_NONE;
    if (byte_go) begin
      unique case (phase_r)
        PH_SEQ: xor_nxt = rx_byte;
        PH_CMD: begin
          cmd_nxt = rx_byte;
          xor_nxt = xor_r ^ rx_byte;
        end
        PH_LEN: begin
          if (too_long) begin
            status = ST_LEN;
          end else begin
            len_nxt = rx_byte[LEN_W-1:0];
            xor_nxt = xor_r ^ rx_byte;
            cnt_nxt = '0;
          end
        end
        PH_PAY: begin
          if (cnt_r == LEN_W'(0)) begin
            pay0_nxt = rx_byte;
          end else if (cnt_r == LEN_W'(1)) begin
            pay1_nxt = rx_byte;
          end
          xor_nxt = xor_r ^ rx_byte;
          cnt_nxt = cnt_inc;
        end
        PH_SUM:  status = (rx_byte == xor_r) ? ST_OK : ST_CSUM;
        default: status = ST_NONE;
      endcase
    end
  end

  always_comb begin
    ev.is_tick = (op == OP_TICK);
    ev.status  = status;
    ev.cmd     = cmd_r;
    ev.pay0    = pay0_r;
    ev.pay1    = pay1_r;
    ev.len_ge2 = (len_r >= LEN_W'(2));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_HDR1;
      cmd_r   <= '0;
      len_r   <= '0;
      cnt_r   <= '0;
      xor_r   <= '0;
      pay0_r  <= '0;
      pay1_r  <= '0;
    end else begin
      phase_r <= phase_nxt;
      cmd_r   <= cmd_nxt;
      len_r   <= len_nxt;
      cnt_r   <= cnt_nxt;
      xor_r   <= xor_nxt;
      pay0_r  <= pay0_nxt;
      pay1_r  <= pay1_nxt;
    end
  end
endmodule

### sv/mcfr_back.sv
// Drive executor: applies frame commands, runs the watchdog, builds each result.
`timescale 1ns / 1ps
module mcfr_back import mcfr_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        go,
  input  ev_t         ev,
  input  logic [15:0] limit,
  output res_t        res
);
  logic [7:0]  lcmd_r, lcmd_nxt;
  logic [7:0]  rcmd_r, rcmd_nxt;
  logic [7:0]  lapp_r, lapp_nxt;
  logic [7:0]  rapp_r, rapp_nxt;
  logic [15:0] elapsed_r, elapsed_nxt;
  logic        link_r, link_nxt;
  logic [15:0] elapsed_inc;
  logic        beep, odo_rst;
  logic [7:0]  accepted;

  assign elapsed_inc = (elapsed_r != 16'hFFFF) ? elapsed_r + 16'd1 : elapsed_r;

  always_comb begin
    lcmd_nxt    = lcmd_r;
    rcmd_nxt    = rcmd_r;
    lapp_nxt    = lapp_r;
    rapp_nxt    = rapp_r;
    elapsed_nxt = elapsed_r;
    link_nxt    = link_r;
    beep        = 1'b0;
    odo_rst     = 1'b0;
    accepted    = '0;
    if (go) begin
      if (ev.is_tick) begin
        elapsed_nxt = elapsed_inc;
        if ((elapsed_inc > limit) && ((lcmd_r != 8'd0) || (rcmd_r != 8'd0))) begin
          lapp_nxt = '0;
          rapp_nxt = '0;
        end
      end else if (ev.status == ST_OK) begin
        elapsed_nxt = '0;
        link_nxt    = 1'b1;
        accepted    = ev.cmd;
        unique case (ev.cmd)
          CMD_HALT_ALL: begin
            lcmd_nxt = '0;
            rcmd_nxt = '0;
            lapp_nxt = '0;
            rapp_nxt = '0;
          end
          CMD_SET_DRIVES: begin
            if (ev.len_ge2) begin
              lcmd_nxt = ev.pay0;
              rcmd_nxt = ev.pay1;
              lapp_nxt = ev.pay0;
              rapp_nxt = ev.pay1;
            end
          end
          CMD_BUZZER:   beep    = 1'b1;
          CMD_ODOM_RST: odo_rst = 1'b1;
          default:      accepted = ev.cmd;
        endcase
      end
    end
  end

  always_comb begin
    res.left    = decode_drive(lapp_nxt);
    res.right   = decode_drive(rapp_nxt);
    res.status  = ev.is_tick ? ST_NONE : ev.status;
    res.cmd     = accepted;
    res.beep    = beep;
    res.odo_rst = odo_rst;
    res.holding = (elapsed_nxt > limit) && ((lcmd_nxt != 8'd0) || (rcmd_nxt != 8'd0));
    res.link    = link_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lcmd_r    <= '0;
      rcmd_r    <= '0;
      lapp_r    <= '0;
      rapp_r    <= '0;
      elapsed_r <= '0;
      link_r    <= 1'b0;
    end else begin
      lcmd_r    <= lcmd_nxt;
      rcmd_r    <= rcmd_nxt;
      lapp_r    <= lapp_nxt;
      rapp_r    <= rapp_nxt;
      elapsed_r <= elapsed_nxt;
      link_r    <= link_nxt;
    end
  end
endmodule

### sv/motor_command_frame_receiver_core.sv
// Motor command frame receiver: parser front, event queue, drive back end and result queue.
`timescale 1ns / 1ps
// Each input transaction is a serial byte or a millisecond tick and yields exactly one
// result. One transaction is accepted per clock when the queues are not backed up; a
// result is registered in the event queue by the parser, then in the result queue by the
// executor, before it shows on the out_ ports. Both queues hold QUEUE_DEPTH entries, so
// input keeps flowing while a finished result waits for pop.
// Header bytes and the watchdog limit sit at byte addresses 0, 4 and 8 of the APB port.
module motor_command_frame_receiver_core import mcfr_pkg::*; #(
  parameter int MAX_PAYLOAD = MAX_PAYLOAD_DEF,
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        push,
  output logic        full,
  input  logic        in_op,
  input  logic [7:0]  in_rx_byte,
  output logic        empty,
  input  logic        pop,
  output logic        out_left_forward,
  output logic        out_left_reverse,
  output logic [7:0]  out_left_duty,
  output logic        out_right_forward,
  output logic        out_right_reverse,
  output logic [7:0]  out_right_duty,
  output logic [1:0]  out_frame_status,
  output logic [7:0]  out_frame_command,
  output logic        out_beep_pulse,
  output logic        out_odometry_reset_pulse,
  output logic        out_watchdog_holding,
  output logic        out_link_seen,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  logic [7:0]  hdr1_r, hdr2_r;
  logic [15:0] limit_r;
  reg_idx_t    reg_idx;
  logic        cfg_wr;

  logic        in_go;
  ev_t         ev_in, ev_out;
  logic        ev_full, ev_empty, ev_pop;
  res_t        res_in, res_out;
  logic        res_full;

  assign pready  = 1'b1;
  assign reg_idx = reg_idx_t'(paddr[3:2]);
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_comb begin
    unique case (reg_idx)
      REG_HDR1:  prdata = {24'd0, hdr1_r};
      REG_HDR2:  prdata = {24'd0, hdr2_r};
      REG_LIMIT: prdata = {16'd0, limit_r};
      default:   prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hdr1_r  <= HDR1_RST;
      hdr2_r  <= HDR2_RST;
      limit_r <= LIMIT_RST;
    end else if (cfg_wr) begin
      unique case (reg_idx)
        REG_HDR1:  hdr1_r  <= pwdata[7:0];
        REG_HDR2:  hdr2_r  <= pwdata[7:0];
        REG_LIMIT: limit_r <= pwdata[15:0];
        default:   hdr1_r  <= hdr1_r;
      endcase
    end
  end

  assign full  = ev_full;
  assign in_go = push && !ev_full;

  mcfr_front #(.MAX_PAYLOAD(MAX_PAYLOAD)) u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .accept  (in_go),
    .op      (in_op),
    .rx_byte (in_rx_byte),
    .hdr1    (hdr1_r),
    .hdr2    (hdr2_r),
    .ev      (ev_in)
  );

  mcfr_fifo #(.W($bits(ev_t)), .DEPTH(QUEUE_DEPTH)) u_ev_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (in_go),
    .din   (ev_in),
    .full  (ev_full),
    .pop   (ev_pop),
    .dout  (ev_out),
    .empty (ev_empty)
  );

  assign ev_pop = !ev_empty && !res_full;

  mcfr_back u_back (
    .clk   (clk),
    .rst_n (rst_n),
    .go    (ev_pop),
    .ev    (ev_out),
    .limit (limit_r),
    .res   (res_in)
  );

  mcfr_fifo #(.W($bits(res_t)), .DEPTH(QUEUE_DEPTH)) u_res_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (ev_pop),
    .din   (res_in),
    .full  (res_full),
    .pop   (pop),
    .dout  (res_out),
    .empty (empty)
  );

  assign out_left_forward         = res_out.left.fwd;
  assign out_left_reverse         = res_out.left.rev;
  assign out_left_duty            = res_out.left.duty;
  assign out_right_forward        = res_out.right.fwd;
  assign out_right_reverse        = res_out.right.rev;
  assign out_right_duty           = res_out.right.duty;
  assign out_frame_status         = res_out.status;
  assign out_frame_command        = res_out.cmd;
  assign out_beep_pulse           = res_out.beep;
  assign out_odometry_reset_pulse = res_out.odo_rst;
  assign out_watchdog_holding     = res_out.holding;
  assign out_link_seen            = res_out.link;
endmodule

### sv/mcfr_checker.sv
// Port-level checks for the motor command frame receiver, bound to the top level.
`timescale 1ns / 1ps
module mcfr_checker import mcfr_pkg::*; (
  input logic       clk,
  input logic       rst_n,
  input logic       empty,
  input logic       full,
  input logic       out_left_forward,
  input logic       out_left_reverse,
  input logic [7:0] out_left_duty,
  input logic [1:0] out_frame_status,
  input logic [7:0] out_frame_command,
  input logic       out_beep_pulse,
  input logic       out_odometry_reset_pulse,
  input logic       out_link_seen
);
  a_reset_clears: assert property (@(posedge clk) !rst_n |=> empty && !full)
    else $error("queues not empty after reset");

  a_cmd_only_on_ok: assert property (@(posedge clk) disable iff (!rst_n)
    !empty && (out_frame_status != ST_OK) |->
      (out_frame_command == 8'd0) && !out_beep_pulse && !out_odometry_reset_pulse)
    else $error("command reported without valid frame");

  a_ok_sets_link: assert property (@(posedge clk) disable iff (!rst_n)
    !empty && (out_frame_status == ST_OK) |-> out_link_seen)
    else $error("valid frame without link flag");

  a_left_pins: assert property (@(posedge clk) disable iff (!rst_n)
    !empty |-> !(out_left_forward && out_left_reverse) &&
      ((out_left_forward || out_left_reverse) == (out_left_duty != 8'd0)))
    else $error("left bridge pins inconsistent with duty");

  a_pulse_excl: assert property (@(posedge clk) disable iff (!rst_n)
    !empty |-> !(out_beep_pulse && out_odometry_reset_pulse))
    else $error("beep and odometry reset in one transaction");
endmodule

bind motor_command_frame_receiver_core mcfr_checker u_mcfr_checker (.*);

### test/tb.sv
// Testbench for the motor command frame receiver: directed and random byte/tick streams
// checked against an in-bench deframer and watchdog predictor.
`timescale 1ns / 1ps
module tb;
  import mcfr_pkg::*;

  localparam int HOLD_CYCLES  = 300;
  localparam int PHASE_ITEMS  = 120;
  localparam int SETTLE_TICKS = 4;

  logic        clk;
  logic        rst_n;
  logic        push;
  logic        full;
  logic        in_op;
  logic [7:0]  in_rx_byte;
  logic        empty;
  logic        pop;
  logic        out_left_forward;
  logic        out_left_reverse;
  logic [7:0]  out_left_duty;
  logic        out_right_forward;
  logic        out_right_reverse;
  logic [7:0]  out_right_duty;
  logic [1:0]  out_frame_status;
  logic [7:0]  out_frame_command;
  logic        out_beep_pulse;
  logic        out_odometry_reset_pulse;
  logic        out_watchdog_holding;
  logic        out_link_seen;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [3:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  motor_command_frame_receiver_core dut (
    .clk(clk), .rst_n(rst_n),
    .push(push), .full(full), .in_op(in_op), .in_rx_byte(in_rx_byte),
    .empty(empty), .pop(pop),
    .out_left_forward(out_left_forward), .out_left_reverse(out_left_reverse),
    .out_left_duty(out_left_duty),
    .out_right_forward(out_right_forward), .out_right_reverse(out_right_reverse),
    .out_right_duty(out_right_duty),
    .out_frame_status(out_frame_status), .out_frame_command(out_frame_command),
    .out_beep_pulse(out_beep_pulse), .out_odometry_reset_pulse(out_odometry_reset_pulse),
    .out_watchdog_holding(out_watchdog_holding), .out_link_seen(out_link_seen),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  // predictor configuration and state
  logic [7:0]  hdr_first;
  logic [7:0]  hdr_second;
  logic [15:0] wd_limit;
  phase_t      phase;
  logic [7:0]  cmd_byte;
  logic [5:0]  frame_len;
  logic [5:0]  pay_count;
  logic [7:0]  csum;
  logic [7:0]  pay0;
  logic [7:0]  pay1;
  logic [7:0]  left_cmd;
  logic [7:0]  right_cmd;
  logic [7:0]  left_app;
  logic [7:0]  right_app;
  logic [15:0] ms_elapsed;
  logic        link_flag;

  res_t predicted_reports[$];
  int   mismatches;
  int   items_sent;
  bit   steady;
  int   tick_pct;
  int   hold_asked;
  int   hold_seen;
  int   hold_cnt;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #(5_000_000);
    $display("tb NOT OK");
    $finish;
  end

  function automatic drive_t drive_levels(logic [7:0] v);
    drive_t d;
    d.fwd  = (v != 8'd0) && (v < 8'h80);
    d.rev  = (v >= 8'h80);
    d.duty = (v >= 8'h80) ? 8'(9'd256 - {1'b0, v}) : v;
    return d;
  endfunction

  function automatic void reset_predictor();
    hdr_first  = HDR1_RST;
    hdr_second = HDR2_RST;
    wd_limit   = LIMIT_RST;
    phase      = PH_HDR1;
    cmd_byte   = 8'd0;
    frame_len  = 6'd0;
    pay_count  = 6'd0;
    csum       = 8'd0;
    pay0       = 8'd0;
    pay1       = 8'd0;
    left_cmd   = 8'd0;
    right_cmd  = 8'd0;
    left_app   = 8'd0;
    right_app  = 8'd0;
    ms_elapsed = 16'd0;
    link_flag  = 1'b0;
  endfunction

  function automatic res_t deframe_step(logic op, logic [7:0] b);
    res_t    r;
    status_t st;
    logic [7:0] acc;
    logic    bp;
    logic    od;
    st  = ST_NONE;
    acc = 8'd0;
    bp  = 1'b0;
    od  = 1'b0;
    if (op == OP_TICK) begin
      if (ms_elapsed != 16'hFFFF) ms_elapsed = ms_elapsed + 16'd1;
      if (ms_elapsed > wd_limit && (left_cmd != 8'd0 || right_cmd != 8'd0)) begin
        left_app  = 8'd0;
        right_app = 8'd0;
      end
    end else begin
      case (phase)
        PH_HDR2: phase = (b == hdr_second) ? PH_SEQ : PH_HDR1;
        PH_SEQ: begin
          csum  = b;
          phase = PH_CMD;
        end
        PH_CMD: begin
          cmd_byte = b;
          csum     = csum ^ b;
          phase    = PH_LEN;
        end
        PH_LEN: begin
          if (b > MAX_PAYLOAD_DEF) begin
            st    = ST_LEN;
            phase = PH_HDR1;
          end else begin
            frame_len = b[5:0];
            csum      = csum ^ b;
            pay_count = 6'd0;
            phase     = (b == 8'd0) ? PH_SUM : PH_PAY;
          end
        end
        PH_PAY: begin
          if (pay_count == 6'd0) pay0 = b;
          else if (pay_count == 6'd1) pay1 = b;
          csum      = csum ^ b;
          pay_count = pay_count + 6'd1;
          if (pay_count >= frame_len) phase = PH_SUM;
        end
        PH_SUM: begin
          phase = PH_HDR1;
          if (b != csum) begin
            st = ST_CSUM;
          end else begin
            st         = ST_OK;
            acc        = cmd_byte;
            ms_elapsed = 16'd0;
            link_flag  = 1'b1;
            case (cmd_byte)
              CMD_HALT_ALL: begin
                left_cmd  = 8'd0;
                right_cmd = 8'd0;
                left_app  = 8'd0;
                right_app = 8'd0;
              end
              CMD_SET_DRIVES: begin
                if (frame_len >= 6'd2) begin
                  left_cmd  = pay0;
                  right_cmd = pay1;
                  left_app  = pay0;
                  right_app = pay1;
                end
              end
              CMD_BUZZER:   bp = 1'b1;
              CMD_ODOM_RST: od = 1'b1;
              default: ;
            endcase
          end
        end
        default: phase = (b == hdr_first) ? PH_HDR2 : PH_HDR1;
      endcase
    end
    r.left    = drive_levels(left_app);
    r.right   = drive_levels(right_app);
    r.status  = st;
    r.cmd     = acc;
    r.beep    = bp;
    r.odo_rst = od;
    r.holding = (ms_elapsed > wd_limit) && (left_cmd != 8'd0 || right_cmd != 8'd0);
    r.link    = link_flag;
    return r;
  endfunction

  task automatic check_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      mismatches++;
      if (mismatches <= 100)
        $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
    end
  endtask

  // receiver: random pop, with an occasional long hold-off
  always @(posedge clk) begin
    if (hold_seen != hold_asked) begin
      hold_seen = hold_asked;
      hold_cnt  = HOLD_CYCLES;
    end
    if (hold_cnt > 0) begin
      hold_cnt--;
      pop <= 1'b0;
    end else begin
      pop <= steady || ($urandom_range(99) >= 22);
    end
  end

  always @(posedge clk) begin
    res_t want;
    if (rst_n && pop && !empty) begin
      if (predicted_reports.size() == 0) begin
        mismatches++;
        $display("%0t: unexpected transaction, expected none, actual cmd %0h status %0h",
                 $time, out_frame_command, out_frame_status);
      end else begin
        want = predicted_reports.pop_front();
        check_field("left_forward", want.left.fwd, out_left_forward);
        check_field("left_reverse", want.left.rev, out_left_reverse);
        check_field("left_duty", want.left.duty, out_left_duty);
        check_field("right_forward", want.right.fwd, out_right_forward);
        check_field("right_reverse", want.right.rev, out_right_reverse);
        check_field("right_duty", want.right.duty, out_right_duty);
        check_field("frame_status", want.status, out_frame_status);
        check_field("frame_command", want.cmd, out_frame_command);
        check_field("beep_pulse", want.beep, out_beep_pulse);
        check_field("odometry_reset_pulse", want.odo_rst, out_odometry_reset_pulse);
        check_field("watchdog_holding", want.holding, out_watchdog_holding);
        check_field("link_seen", want.link, out_link_seen);
      end
    end
  end

  task automatic send_item(logic op, logic [7:0] b);
    while (!steady && $urandom_range(99) < 22) begin
      push <= 1'b0;
      @(posedge clk);
    end
    push       <= 1'b1;
    in_op      <= op;
    in_rx_byte <= b;
    do @(posedge clk); while (full);
    predicted_reports.push_back(deframe_step(op, b));
    items_sent++;
  endtask

  task automatic send_tick();
    send_item(OP_TICK, 8'($urandom));
  endtask

  task automatic maybe_tick();
    if ($urandom_range(99) < tick_pct) send_tick();
  endtask

  task automatic send_frame(logic [7:0] cmd, logic [7:0] len, logic [7:0] p0,
                            logic [7:0] p1, bit bad_sum);
    logic [7:0] seq_byte;
    logic [7:0] sum;
    logic [7:0] b;
    seq_byte = 8'($urandom);
    send_item(OP_BYTE, hdr_first);
    send_item(OP_BYTE, hdr_second);
    send_item(OP_BYTE, seq_byte);
    maybe_tick();
    send_item(OP_BYTE, cmd);
    send_item(OP_BYTE, len);
    if (len > MAX_PAYLOAD_DEF) return;
    sum = seq_byte ^ cmd ^ len;
    for (int i = 0; i < len; i++) begin
      b   = (i == 0) ? p0 : (i == 1) ? p1 : 8'($urandom);
      sum = sum ^ b;
      send_item(OP_BYTE, b);
      maybe_tick();
    end
    if (bad_sum) sum = sum ^ (8'd1 << $urandom_range(7));
    send_item(OP_BYTE, sum);
  endtask

  task automatic drain();
    push <= 1'b0;
    while (predicted_reports.size() != 0) @(posedge clk);
    repeat (SETTLE_TICKS) @(posedge clk);
  endtask

  task automatic write_reg(reg_idx_t idx, logic [31:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (idx)
      REG_HDR1:  hdr_first  = val[7:0];
      REG_HDR2:  hdr_second = val[7:0];
      REG_LIMIT: wd_limit   = val[15:0];
      default: ;
    endcase
    @(posedge clk);
  endtask

  function automatic logic [7:0] pick_drive();
    case ($urandom_range(7))
      0: return 8'h00;
      1: return 8'h01;
      2: return 8'h7F;
      3: return 8'h80;
      4: return 8'hFF;
      default: return 8'($urandom);
    endcase
  endfunction

  function automatic logic [7:0] pick_cmd();
    case ($urandom_range(9))
      0, 1: return CMD_HALT_ALL;
      2, 3, 4: return CMD_SET_DRIVES;
      5: return CMD_BUZZER;
      6: return CMD_ODOM_RST;
      7: return 8'h03;
      8: return 8'h05;
      default: return 8'($urandom);
    endcase
  endfunction

  function automatic logic [7:0] pick_len();
    int r;
    r = $urandom_range(99);
    if (r < 8) return 8'd0;
    if (r < 80) return 8'($urandom_range(1, 6));
    if (r < 90) return 8'($urandom_range(7, MAX_PAYLOAD_DEF));
    if (r < 95) return 8'(MAX_PAYLOAD_DEF);
    return 8'($urandom_range(MAX_PAYLOAD_DEF + 1, 255));
  endfunction

  task automatic send_random_unit();
    int r;
    r = $urandom_range(99);
    if (r < 8) begin
      repeat ($urandom_range(1, 3)) send_item(OP_BYTE, 8'($urandom));
    end else if (r < 14) begin
      send_item(OP_BYTE, hdr_first);
      repeat ($urandom_range(1, 3)) send_item(OP_BYTE, 8'($urandom));
    end else if (r < 22) begin
      repeat ($urandom_range(1, 4)) send_tick();
    end else begin
      send_frame(pick_cmd(), pick_len(), pick_drive(), pick_drive(),
                 $urandom_range(99) < 10);
    end
  endtask

  task automatic test_directed();
    tick_pct = 0;
    send_item(OP_BYTE, 8'h00);
    send_item(OP_BYTE, 8'hFF);
    send_item(OP_BYTE, hdr_first);
    send_item(OP_BYTE, 8'h00);
    send_frame(CMD_SET_DRIVES, 8'd2, 8'h7F, 8'h80, 1'b0);
    send_tick();
    send_frame(CMD_BUZZER, 8'd0, 8'h00, 8'h00, 1'b0);
    send_frame(CMD_SET_DRIVES, 8'd33, 8'h00, 8'h00, 1'b0);
    send_frame(CMD_ODOM_RST, 8'd1, 8'h55, 8'h00, 1'b1);
    send_frame(CMD_HALT_ALL, 8'd0, 8'h00, 8'h00, 1'b0);
    drain();
  endtask

  task automatic test_watchdog();
    tick_pct = 0;
    write_reg(REG_LIMIT, 32'd2);
    send_frame(CMD_SET_DRIVES, 8'd2, 8'h01, 8'hFF, 1'b0);
    repeat (4) send_tick();
    send_frame(CMD_SET_DRIVES, 8'd1, 8'h10, 8'h00, 1'b0);
    repeat (4) send_tick();
    drain();
    write_reg(REG_LIMIT, 32'd0);
    send_frame(CMD_SET_DRIVES, 8'd2, 8'h80, 8'h00, 1'b0);
    send_tick();
    send_frame(CMD_HALT_ALL, 8'd0, 8'h00, 8'h00, 1'b0);
    send_tick();
    drain();
    write_reg(REG_LIMIT, 32'(LIMIT_RST));
  endtask

  task automatic test_header_bytes();
    logic [7:0] firsts[3];
    logic [7:0] seconds[3];
    firsts  = '{8'h00, 8'hFF, 8'h5A};
    seconds = '{8'hFF, 8'h00, 8'h5A};
    tick_pct = 10;
    for (int i = 0; i < 3; i++) begin
      drain();
      write_reg(REG_HDR1, 32'(firsts[i]));
      write_reg(REG_HDR2, 32'(seconds[i]));
      repeat (6) send_random_unit();
    end
    drain();
    write_reg(REG_HDR1, 32'(HDR1_RST));
    write_reg(REG_HDR2, 32'(HDR2_RST));
  endtask

  task automatic test_backpressure();
    tick_pct = 10;
    hold_asked++;
    repeat (6) send_random_unit();
    send_frame(CMD_SET_DRIVES, 8'd4, pick_drive(), pick_drive(), 1'b0);
    drain();
  endtask

  task automatic test_random();
    int limits[5];
    int start;
    limits = '{3, 0, 12, 40, 65535};
    tick_pct = 10;
    for (int i = 0; i < 5; i++) begin
      drain();
      write_reg(REG_LIMIT, 32'(limits[i]));
      steady = (i == 0);
      start  = items_sent;
      while (items_sent - start < PHASE_ITEMS) send_random_unit();
    end
    steady = 1'b0;
  endtask

  initial begin
    rst_n      = 1'b0;
    push       = 1'b0;
    in_op      = OP_BYTE;
    in_rx_byte = 8'd0;
    pop        = 1'b0;
    psel       = 1'b0;
    penable    = 1'b0;
    pwrite     = 1'b0;
    paddr      = 4'd0;
    pwdata     = 32'd0;
    mismatches = 0;
    items_sent = 0;
    steady     = 1'b0;
    tick_pct   = 0;
    hold_asked = 0;
    hold_seen  = 0;
    hold_cnt   = 0;
    reset_predictor();
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_watchdog();
    test_header_bytes();
    test_backpressure();
    test_random();
    drain();
    if (mismatches == 0 && predicted_reports.size() == 0) begin
      $display("tb OK");
    end else begin
      $display("tb NOT OK");
    end
    $finish;
  end

endmodule

### filelist.f
sv/mcfr_pkg.sv
sv/mcfr_fifo.sv
sv/mcfr_front.sv
sv/mcfr_back.sv
sv/motor_command_frame_receiver_core.sv
sv/mcfr_checker.sv
test/tb.sv
